>>> rtl/pmdm_pkg.sv
package pmdm_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int MAX_FIELDS  = 32;

    localparam int REC_W   = $clog2(MAX_RECORDS);
    localparam int FLD_W   = $clog2(MAX_FIELDS);
    localparam int ADDR_W  = REC_W + FLD_W;
    localparam int DEPTH   = MAX_RECORDS * MAX_FIELDS;
    localparam int RC_W    = $clog2(MAX_RECORDS + 1);
    localparam int FC_W    = $clog2(MAX_FIELDS + 1);
    localparam int DIST_W  = FLD_W;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = (RC_W > FC_W) ? RC_W : FC_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_COUNT  = CFG_IDX_W'(1);

    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [RC_W-1:0] RC_RESET = RC_W'(64);
    localparam logic [FC_W-1:0] FC_RESET = FC_W'(23);

    typedef struct packed {
        logic              operation;
        logic [REC_W-1:0]  record_index;
        logic [FLD_W-1:0]  position;
        logic [BYTE_W-1:0] attribute_value;
    } t_in_item;

    typedef struct packed {
        logic [REC_W-1:0]  column_index;
        logic [DIST_W-1:0] distance;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [RC_W-1:0] record_count;
        logic [FC_W-1:0] field_count;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
    } t_rd_addr;

endpackage

>>> rtl/pmdm_store.sv
module pmdm_store (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [pmdm_pkg::ADDR_W-1:0]  i_waddr,
    input  logic [pmdm_pkg::BYTE_W-1:0]  i_wdata,
    input  pmdm_pkg::t_rd_addr           i_rd,
    output logic [pmdm_pkg::BYTE_W-1:0]  o_rdata_a,
    output logic [pmdm_pkg::BYTE_W-1:0]  o_rdata_b
);

    logic [pmdm_pkg::BYTE_W-1:0] r_mem [0:pmdm_pkg::DEPTH-1];
    logic [pmdm_pkg::BYTE_W-1:0] r_rdata_a;
    logic [pmdm_pkg::BYTE_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_rd.addr_a];
        r_rdata_b <= r_mem[i_rd.addr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> rtl/pmdm_seq.sv
module pmdm_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req,
    input  logic [pmdm_pkg::REC_W-1:0]   i_rec,
    input  pmdm_pkg::t_cfg               i_cfg,
    input  logic [pmdm_pkg::BYTE_W-1:0]  i_rdata_a,
    input  logic [pmdm_pkg::BYTE_W-1:0]  i_rdata_b,
    output pmdm_pkg::t_rd_addr           o_rd,
    output logic                         o_busy,
    output logic                         o_strobe,
    output pmdm_pkg::t_out_item          o_result
);

    typedef enum logic [1:0] {
        IDLE,
        RUN,
        DRAIN
    } t_state;

    t_state                       r_state;
    logic [pmdm_pkg::REC_W-1:0]   r_rec;
    logic [pmdm_pkg::REC_W-1:0]   r_col;
    logic [pmdm_pkg::FLD_W-1:0]   r_pos;
    logic [pmdm_pkg::DIST_W-1:0]  r_cnt;
    logic                         r_rd_vld;
    logic                         r_strobe;
    pmdm_pkg::t_out_item          r_result;

    logic                         mismatch;
    logic                         pos_last;
    logic                         col_last;
    logic [pmdm_pkg::DIST_W-1:0]  n_cnt;

    assign mismatch = (i_rdata_a != i_rdata_b);
    assign pos_last = ({1'b0, r_pos} == i_cfg.field_count - pmdm_pkg::FC_W'(1));
    assign col_last = ({1'b0, r_col} + pmdm_pkg::RC_W'(1) == i_cfg.record_count);
    assign n_cnt    = r_cnt + pmdm_pkg::DIST_W'(mismatch);

    assign o_rd.addr_a = {r_rec, r_pos};
    assign o_rd.addr_b = {r_col, r_pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= IDLE;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_rd_vld <= 1'b0;
            if (r_rd_vld) begin
                r_cnt <= n_cnt;
            end
            unique case (r_state)
                IDLE: begin
                    if (i_req) begin
                        r_rec   <= i_rec;
                        r_col   <= '0;
                        r_pos   <= pmdm_pkg::FLD_W'(1);
                        r_cnt   <= '0;
                        r_state <= RUN;
                    end
                end
                RUN: begin
                    r_rd_vld <= 1'b1;
                    if (pos_last) begin
                        r_state <= DRAIN;
                    end else begin
                        r_pos <= r_pos + pmdm_pkg::FLD_W'(1);
                    end
                end
                DRAIN: begin
                    // The last byte pair of this column is on the read ports now.
                    r_strobe              <= 1'b1;
                    r_result.column_index <= r_col;
                    r_result.distance     <= (r_col == r_rec) ? '0 : n_cnt;
                    r_result.last         <= col_last;
                    r_cnt                 <= '0;
                    r_pos                 <= pmdm_pkg::FLD_W'(1);
                    if (col_last) begin
                        r_state <= IDLE;
                    end else begin
                        r_col   <= r_col + pmdm_pkg::REC_W'(1);
                        r_state <= RUN;
                    end
                end
                default: r_state <= IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

>>> rtl/pairwise_mismatch_distance_matrix.sv
// Pairwise mismatch distance over a table of categorical records.
// Items enter on i_item and are taken at a clock edge where start is high
// and busy is low. A store item writes one attribute byte and yields no
// result; busy stays low, so stores can arrive every cycle outside a row.
// A row request compares the named record with records 0 .. record_count-1.
// Each column passes through RUN, which reads one byte pair per cycle from
// the dual-read record memory for positions 1 .. field_count-1, and then
// DRAIN, which closes the count and registers the column's result. busy
// stays high for the whole row. Results show on o_result for one cycle
// with o_strobe high; the receiver cannot stall, so nothing is held back.
// last marks the final column. Registers are written through i_cfg_valid /
// o_cfg_ready (always ready); the user must write them only while the block
// is idle, and the block itself does not enforce this. Values are saturated
// into their legal range. Reset returns the sequencer to idle and restores
// record_count = 64 and field_count = 23. The record memory is not cleared.
module pairwise_mismatch_distance_matrix (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  pmdm_pkg::t_in_item               i_item,
    output logic                             o_strobe,
    output pmdm_pkg::t_out_item              o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pmdm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pmdm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    pmdm_pkg::t_cfg                 r_cfg;
    pmdm_pkg::t_rd_addr             rd;
    logic [pmdm_pkg::BYTE_W-1:0]    rdata_a;
    logic [pmdm_pkg::BYTE_W-1:0]    rdata_b;
    logic                           accept;
    logic                           store_we;
    logic                           req;
    logic [pmdm_pkg::RC_W-1:0]      rc_raw;
    logic [pmdm_pkg::FC_W-1:0]      fc_raw;
    logic [pmdm_pkg::RC_W-1:0]      n_rc;
    logic [pmdm_pkg::FC_W-1:0]      n_fc;

    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign store_we    = accept && (i_item.operation == pmdm_pkg::OP_STORE);
    assign req         = accept && (i_item.operation == pmdm_pkg::OP_REQUEST);

    assign rc_raw = i_cfg_data[pmdm_pkg::RC_W-1:0];
    assign fc_raw = i_cfg_data[pmdm_pkg::FC_W-1:0];

    always_comb begin
        if (rc_raw == '0) begin
            n_rc = pmdm_pkg::RC_W'(1);
        end else if (rc_raw > pmdm_pkg::RC_W'(pmdm_pkg::MAX_RECORDS)) begin
            n_rc = pmdm_pkg::RC_W'(pmdm_pkg::MAX_RECORDS);
        end else begin
            n_rc = rc_raw;
        end
        if (fc_raw < pmdm_pkg::FC_W'(2)) begin
            n_fc = pmdm_pkg::FC_W'(2);
        end else if (fc_raw > pmdm_pkg::FC_W'(pmdm_pkg::MAX_FIELDS)) begin
            n_fc = pmdm_pkg::FC_W'(pmdm_pkg::MAX_FIELDS);
        end else begin
            n_fc = fc_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.record_count <= pmdm_pkg::RC_RESET;
            r_cfg.field_count  <= pmdm_pkg::FC_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == pmdm_pkg::CFG_RECORD_COUNT) begin
                r_cfg.record_count <= n_rc;
            end else if (i_cfg_index == pmdm_pkg::CFG_FIELD_COUNT) begin
                r_cfg.field_count <= n_fc;
            end
        end
    end

    pmdm_store u_store (
        .i_clk     (i_clk),
        .i_we      (store_we),
        .i_waddr   ({i_item.record_index, i_item.position}),
        .i_wdata   (i_item.attribute_value),
        .i_rd      (rd),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    pmdm_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_rec     (i_item.record_index),
        .i_cfg     (r_cfg),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b),
        .o_rd      (rd),
        .o_busy    (busy),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule

>>> rtl/pmdm_checker.sv
module pmdm_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  pmdm_pkg::t_in_item   i_item,
    input  logic                 o_strobe,
    input  pmdm_pkg::t_out_item  o_result
);

    // A row request always occupies the block.
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.operation == pmdm_pkg::OP_REQUEST) |=> busy)
        else $error("row request did not raise busy");

    // A store finishes in the cycle it is taken.
    a_store_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.operation == pmdm_pkg::OP_STORE) |=> !busy)
        else $error("store item raised busy");

    // A row still in progress keeps the block busy.
    a_mid_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> busy)
        else $error("busy low before the last column");

    // Each column passes through RUN before DRAIN, so results never come back to back.
    a_no_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results on consecutive cycles");

endmodule

bind pairwise_mismatch_distance_matrix pmdm_checker u_pmdm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

>>> tb/sv/tb_pairwise_mismatch_distance_matrix.sv
module tb_pairwise_mismatch_distance_matrix;
    import pmdm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);
    localparam int SETTLE_CYCLES  = 2 * MAX_FIELDS + 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_in_item              i_item = '0;
    logic                  o_strobe;
    t_out_item             o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    pairwise_mismatch_distance_matrix DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Table copy used for prediction, plus a map of which bytes the stimulus
    // has already loaded so that no row request reads an unwritten byte.
    logic [BYTE_W-1:0] record_bytes [MAX_RECORDS][MAX_FIELDS];
    bit                byte_loaded  [MAX_RECORDS][MAX_FIELDS];

    t_in_item  pending_items[$];
    t_out_item expected_columns[$];

    int cur_record_count = RC_RESET;
    int cur_field_count  = FC_RESET;
    int sender_idle_pct  = 0;

    int items_queued      = 0;
    int items_taken       = 0;
    int phase_items       = 0;
    int stores_taken      = 0;
    int requests_taken    = 0;
    int results_checked   = 0;
    int registers_written = 0;
    int mismatch_count    = 0;
    int quiet_cycles      = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int clamp_count(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // One expected result per column 0 .. record_count-1. The label at
    // position zero never takes part in the count.
    function automatic void compute_row_distances(input int row);
        t_out_item want;
        int        diff;
        for (int col = 0; col < cur_record_count; col++) begin
            diff = 0;
            for (int pos = 1; pos < cur_field_count; pos++) begin
                if (record_bytes[row][pos] != record_bytes[col][pos])
                    diff++;
            end
            want.column_index = REC_W'(col);
            want.distance     = DIST_W'(diff);
            want.last         = (col + 1 == cur_record_count);
            expected_columns.insert(expected_columns.size(), want);
        end
    endfunction

    function automatic void flag_mismatch(input string what, input t_out_item want,
                                          input t_out_item got);
        if (mismatch_count < REPORT_LIMIT)
            $display(
                "MISMATCH (%s): expected col %0d dist %0d last %0d, got col %0d dist %0d last %0d",
                what, want.column_index, want.distance, want.last,
                got.column_index, got.distance, got.last);
        mismatch_count++;
    endfunction

    function automatic logic [BYTE_W-1:0] random_byte();
        // Mostly a small alphabet so that rows show a spread of distances.
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 8'h61 + BYTE_W'($urandom_range(0, 2));
            9: return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    function automatic int pick_record();
        if ($urandom_range(0, 99) < 75)
            return $urandom_range(0, cur_record_count - 1);
        return $urandom_range(0, MAX_RECORDS - 1);
    endfunction

    function automatic int pick_position();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, cur_field_count - 1);
        return $urandom_range(0, MAX_FIELDS - 1);
    endfunction

    function automatic void queue_store(input int rec, input int pos,
                                        input logic [BYTE_W-1:0] value);
        t_in_item it;
        it.operation       = OP_STORE;
        it.record_index    = REC_W'(rec);
        it.position        = FLD_W'(pos);
        it.attribute_value = value;
        pending_items.insert(pending_items.size(), it);
        byte_loaded[rec][pos] = 1'b1;
        items_queued++;
        phase_items++;
    endfunction

    // Loads any byte the row will read that was never written, then asks
    // for the row. Unused fields of the request carry random bits.
    function automatic void queue_row_request(input int rec);
        t_in_item it;
        int       r;
        for (int c = 0; c <= cur_record_count; c++) begin
            r = (c == cur_record_count) ? rec : c;
            for (int pos = 1; pos < cur_field_count; pos++) begin
                if (!byte_loaded[r][pos])
                    queue_store(r, pos, random_byte());
            end
        end
        it.operation       = OP_REQUEST;
        it.record_index    = REC_W'(rec);
        it.position        = FLD_W'($urandom_range(0, MAX_FIELDS - 1));
        it.attribute_value = BYTE_W'($urandom);
        pending_items.insert(pending_items.size(), it);
        items_queued++;
        phase_items++;
    endfunction

    // Called at a rising edge; leaves valid high so that back-to-back writes
    // need no second assignment in the same step.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1)
            @(posedge i_clk);
        case (idx)
            CFG_RECORD_COUNT: cur_record_count = clamp_count(int'(data[RC_W-1:0]), 1,
                                                             MAX_RECORDS);
            CFG_FIELD_COUNT:  cur_field_count = clamp_count(int'(data[FC_W-1:0]), 2,
                                                            MAX_FIELDS);
            default: ;
        endcase
        registers_written++;
    endtask

    task automatic settle();
        while (items_taken != items_queued || start || busy || expected_columns.size() != 0)
            @(posedge i_clk);
        // A trailing store yields no result, so give it time to land.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] rc_data,
                             input logic [CFG_DATA_W-1:0] fc_data,
                             input int budget, input int idle_pct);
        write_register(CFG_RECORD_COUNT, rc_data);
        write_register(CFG_FIELD_COUNT, fc_data);
        i_cfg_valid <= 1'b0;
        sender_idle_pct = idle_pct;
        phase_items = 0;
        while (phase_items < budget) begin
            if ($urandom_range(0, 99) < 35)
                queue_row_request(pick_record());
            else
                queue_store(pick_record(), pick_position(), random_byte());
        end
        settle();
    endtask

    // Item driver: start is held with its item while busy is high.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                if (i_item.operation == OP_STORE) begin
                    record_bytes[i_item.record_index][i_item.position] = i_item.attribute_value;
                    stores_taken++;
                end else begin
                    compute_row_distances(int'(i_item.record_index));
                    requests_taken++;
                end
                items_taken++;
            end
            if (!(start && busy)) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    start  <= 1'b1;
                    i_item <= pending_items.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (expected_columns.size() == 0) begin
                flag_mismatch("result with nothing expected", '0, o_result);
            end else begin
                if (o_result.column_index !== expected_columns[0].column_index ||
                    o_result.distance !== expected_columns[0].distance ||
                    o_result.last !== expected_columns[0].last)
                    flag_mismatch("wrong field", expected_columns[0], o_result);
                void'(expected_columns.pop_front());
            end
            results_checked++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe === 1'b1 ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("pairwise_mismatch_distance_matrix verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Hand-built rows: an all-equal pair, a pair differing everywhere,
        // a single difference, and a record beyond record_count.
        write_register(CFG_SPARE_2, 7'h55);
        write_register(CFG_RECORD_COUNT, 7'd3);
        write_register(CFG_FIELD_COUNT, 7'd4);
        write_register(CFG_SPARE_3, 7'h2A);
        i_cfg_valid <= 1'b0;
        queue_store(0, 0, 8'hFF);
        queue_store(1, 0, 8'h00);
        for (int pos = 1; pos < 4; pos++) begin
            queue_store(0, pos, 8'h00);
            queue_store(1, pos, 8'hFF);
            queue_store(2, pos, (pos == 2) ? 8'hAA : 8'h00);
        end
        queue_row_request(0);
        queue_row_request(2);
        queue_store(MAX_RECORDS - 1, MAX_FIELDS - 1, 8'hFF);
        for (int pos = 1; pos < 4; pos++)
            queue_store(MAX_RECORDS - 1, pos, 8'h00);
        queue_row_request(MAX_RECORDS - 1);
        queue_store(1, 2, 8'h00);
        queue_row_request(1);
        settle();

        // Out-of-range register values saturate; the last write of each wins.
        write_register(CFG_RECORD_COUNT, 7'd127);
        write_register(CFG_FIELD_COUNT, 7'd63);
        write_register(CFG_RECORD_COUNT, 7'd0);
        write_register(CFG_FIELD_COUNT, 7'd1);
        write_register(CFG_FIELD_COUNT, 7'd0);
        i_cfg_valid <= 1'b0;
        queue_row_request(0);
        queue_row_request(2);
        queue_row_request(MAX_RECORDS - 1);
        settle();

        run_phase(7'd64, 7'd2, 90, 53);
        run_phase(7'd2, 7'd32, 70, 26);
        run_phase(7'd7, 7'd9, 80, 0);
        run_phase(7'd1, 7'd17, 60, 53);
        run_phase(CFG_DATA_W'($urandom_range(1, 12)), CFG_DATA_W'($urandom_range(2, 12)),
                  60, 26);

        mismatch_count += expected_columns.size();
        $display("Run covered %0d stores and %0d row requests over %0d register writes.",
                 stores_taken, requests_taken, registers_written);
        $display("Checked %0d distance results; %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("pairwise_mismatch_distance_matrix verification clean");
        end else begin
            $display("pairwise_mismatch_distance_matrix verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/pmdm_pkg.sv
rtl/pmdm_store.sv
rtl/pmdm_seq.sv
rtl/pairwise_mismatch_distance_matrix.sv
rtl/pmdm_checker.sv
tb/sv/tb_pairwise_mismatch_distance_matrix.sv
